@@ hw/rtl/ptoq_pkg.sv @@
// ----------------------------------------------------------------------------
// ptoq_pkg
// Shared types, sizes and codes of the track ordered request queue.
// ----------------------------------------------------------------------------
package ptoq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int TRACK_W = 10;
  localparam int SECT_W  = 6;
  localparam int TAG_W   = 16;
  localparam int OCC_W   = 5;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_ADDED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_TAKEN  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic [SECT_W-1:0]  sector;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             eval;
    logic             apply_add;
    logic             apply_take;
    entry_t           new_e;
    logic [CNT_W-1:0] count;
  } ctrl_t;

  // occupancy keeps the low bits of the count
  function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] c);
    logic [OCC_W-1:0] r;
    r = '0;
    for (int b = 0; b < OCC_W; b++) begin
      if (b < CNT_W) r[b] = c[b];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ptoq_cell.sv @@
// ----------------------------------------------------------------------------
// ptoq_cell
// One queue slot: holds an entry, tests the insertion rule against its
// successor, and shifts toward the head or the tail.
// ----------------------------------------------------------------------------
module ptoq_cell (
  input  logic                clk,
  input  ptoq_pkg::ctrl_t     ctrl,
  input  logic [ptoq_pkg::CNT_W-1:0] idx,
  input  ptoq_pkg::entry_t    prev_entry,
  input  ptoq_pkg::entry_t    next_entry,
  input  logic                pass_in,
  output logic                pass_out,
  input  logic                aoa_in,
  output logic                aoa_out,
  output ptoq_pkg::entry_t    entry
);
  import ptoq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   m_r, m_nxt;
  logic   in_use, has_next, cond;

  assign in_use   = idx < ctrl.count;
  assign has_next = ({1'b0, idx} + 1'b1) < {1'b0, ctrl.count};

  always_comb begin
    if (entry_r.track == ctrl.new_e.track) begin
      cond = next_entry.track != ctrl.new_e.track;
    end else begin
      cond = (next_entry.track < ctrl.new_e.track) &&
             (entry_r.track > ctrl.new_e.track);
    end
  end

  assign m_nxt = ctrl.eval ? (has_next & cond) : m_r;

  // insertion point lies just after this slot or an earlier one
  assign pass_out = pass_in | m_r;
  assign aoa_out  = pass_in | ~in_use;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.apply_take) begin
      entry_nxt = next_entry;
    end else if (ctrl.apply_add) begin
      if (aoa_in) entry_nxt = prev_entry;
      else if (aoa_out) entry_nxt = ctrl.new_e;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    m_r     <= m_nxt;
  end

  assign entry = entry_r;

endmodule

@@ hw/rtl/pickup_track_order_queue.sv @@
// ----------------------------------------------------------------------------
// pickup_track_order_queue
// Request queue kept in track pickup order in a row of shifting cells.
// ----------------------------------------------------------------------------
// sequence: each cell tests its match flag in the evaluate state; the
//   first-match chain along the row, the shift and the result register act
//   in the apply state, held by an output stall; the next item can enter as it fires
// reset: clears the count, the sequencer and the result valid; slot contents
//   are left as they are and only slots below the count are ever read
module pickup_track_order_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [ptoq_pkg::TRACK_W-1:0]  in_new_track,
  input  logic [ptoq_pkg::SECT_W-1:0]   in_new_sector,
  input  logic [ptoq_pkg::TAG_W-1:0]    in_new_tag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ptoq_pkg::STAT_W-1:0]   out_status,
  output logic [ptoq_pkg::TRACK_W-1:0]  out_track,
  output logic [ptoq_pkg::SECT_W-1:0]   out_sector,
  output logic [ptoq_pkg::TAG_W-1:0]    out_tag,
  output logic [ptoq_pkg::OCC_W-1:0]    out_occupancy
);
  import ptoq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             op_r;
  entry_t           ne_r;
  logic             out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  entry_t           oe_r, oe_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;

  logic   in_fire, can_write, apply_fire, full, empty;
  ctrl_t  ctrl;
  entry_t cell_e [DEPTH];
  logic   pass [DEPTH+1];
  logic   aoa  [DEPTH+1];

  assign full      = count_r == CNT_W'(DEPTH);
  assign empty     = count_r == '0;
  assign can_write = ~out_valid_r | ~out_stall;
  assign apply_fire = (state_r == S_APPLY) && can_write;
  assign in_stall  = ~((state_r == S_IDLE) || apply_fire);
  assign in_fire   = in_valid & ~in_stall;

  assign ctrl.eval       = state_r == S_EVAL;
  assign ctrl.apply_add  = apply_fire && (op_r == OP_ADD) && !full;
  assign ctrl.apply_take = apply_fire && (op_r == OP_TAKE) && !empty;
  assign ctrl.new_e      = ne_r;
  assign ctrl.count      = count_r;

  assign pass[0] = 1'b0;
  assign aoa[0]  = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ptoq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (CNT_W'(g)),
      .prev_entry (g == 0 ? ne_r : cell_e[(g == 0) ? 0 : g-1]),
      .next_entry (g == DEPTH-1 ? cell_e[g] : cell_e[(g == DEPTH-1) ? g : g+1]),
      .pass_in    (pass[g]),
      .pass_out   (pass[g+1]),
      .aoa_in     (aoa[g]),
      .aoa_out    (aoa[g+1]),
      .entry      (cell_e[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = S_APPLY;
      S_APPLY: if (apply_fire) state_nxt = in_fire ? S_EVAL : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r & out_stall;
    status_nxt    = status_r;
    oe_nxt        = oe_r;
    occ_nxt       = occ_r;
    if (apply_fire) begin
      out_valid_nxt = 1'b1;
      oe_nxt        = '0;
      if (op_r == OP_TAKE) begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt = ST_TAKEN;
          oe_nxt     = cell_e[0];
          count_nxt  = count_r - 1'b1;
        end
      end else begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_ADDED;
          count_nxt  = count_r + 1'b1;
        end
      end
      occ_nxt = to_occ(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r         <= in_op;
      ne_r.track   <= in_new_track;
      ne_r.sector  <= in_new_sector;
      ne_r.tag     <= in_new_tag;
    end
    status_r <= status_nxt;
    oe_r     <= oe_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_track     = oe_r.track;
  assign out_sector    = oe_r.sector;
  assign out_tag       = oe_r.tag;
  assign out_occupancy = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("count above depth");

  a_no_accept_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> in_stall)
    else $error("item accepted while slots are being tested");

  a_count_moves_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(apply_fire))
    else $error("count changed outside the shift cycle");

  a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_APPLY))
    else $error("result without a shift cycle");

endmodule
